[hw/rtl/lpd_pkg.sv]
`default_nettype none
package lpd_pkg;

  // Every length and count field is four little-endian bytes.
  localparam int LEN_FIELD_BYTES = 4;

  localparam int BODY_W  = 26;
  localparam int ARGS_W  = 20;
  localparam int ROLE_W  = 3;
  localparam int ERR_W   = 3;
  localparam int FIELD_W = 8 * LEN_FIELD_BYTES;

  localparam logic [BODY_W-1:0] MAX_BODY_RESET = BODY_W'(4096);
  localparam logic [ARGS_W-1:0] MAX_ARGS_RESET = ARGS_W'(200000);

  // Byte roles.
  localparam logic [ROLE_W-1:0] ROLE_BODY_LEN  = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_ARG_COUNT = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_STR_LEN   = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_STR_BYTE  = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_DISCARD   = 3'd4;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BODY_BIG   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MANY_ARGS  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_PAST_END   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TRAILING   = 3'd4;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_BODY = 1'b0;
  localparam logic REG_MAX_ARGS = 1'b1;

  typedef struct packed {
    logic [BODY_W-1:0] max_body_bytes;
    logic [ARGS_W-1:0] max_arg_count;
  } lpd_cfg_t;

  typedef struct packed {
    logic [ERR_W-1:0]  error_code;
    logic              message_done;
    logic              string_last;
    logic [ARGS_W-1:0] arg_index;
    logic [ROLE_W-1:0] byte_role;
    logic [7:0]        byte_out;
  } lpd_result_t;

endpackage
`default_nettype wire

[hw/rtl/lpd_cfg_regs.sv]
`default_nettype none
module lpd_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready,
  output lpd_pkg::lpd_cfg_t      cfg
);

  logic [lpd_pkg::BODY_W-1:0] max_body_r;
  logic [lpd_pkg::ARGS_W-1:0] max_args_r;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= lpd_pkg::MAX_BODY_RESET;
      max_args_r <= lpd_pkg::MAX_ARGS_RESET;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        lpd_pkg::REG_MAX_BODY: max_body_r <= cfg_pwdata[lpd_pkg::BODY_W-1:0];
        lpd_pkg::REG_MAX_ARGS: max_args_r <= cfg_pwdata[lpd_pkg::ARGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      lpd_pkg::REG_MAX_BODY: cfg_prdata = 32'(max_body_r);
      lpd_pkg::REG_MAX_ARGS: cfg_prdata = 32'(max_args_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg.max_body_bytes = max_body_r;
  assign cfg.max_arg_count  = max_args_r;

endmodule
`default_nettype wire

[hw/rtl/lpd_parser.sv]
`default_nettype none
module lpd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                beat_fire,
  input  wire logic [7:0]          data_byte,
  input  wire lpd_pkg::lpd_cfg_t   cfg,
  output lpd_pkg::lpd_result_t     res
);

  typedef enum logic [1:0] {
    PH_BODY_LEN,
    PH_ARG_COUNT,
    PH_STR_LEN,
    PH_STR_BYTES
  } phase_t;

  localparam int BW = lpd_pkg::BODY_W;
  localparam int AW = lpd_pkg::ARGS_W;
  localparam int SW = lpd_pkg::FIELD_W - 8;

  phase_t                    phase_r, phase_nxt;
  logic                      closed_r, closed_nxt;
  logic [lpd_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic [SW-1:0]             shift_r, shift_nxt;
  logic [BW-1:0]             body_r, body_nxt;
  logic [AW-1:0]             args_r, args_nxt;
  logic [AW-1:0]             cur_r, cur_nxt;
  logic [BW-1:0]             str_r, str_nxt;

  logic [lpd_pkg::FIELD_W-1:0] field_full;
  logic                        field_done;
  logic [BW-1:0]               body_dec;
  logic [BW-1:0]               str_dec;
  logic                        item_end;
  logic [AW-1:0]               args_after;
  logic [lpd_pkg::ERR_W-1:0]   fail_code;
  logic                        fail;

  assign field_full = {data_byte, shift_r};
  assign field_done = (cnt_r == 2'(lpd_pkg::LEN_FIELD_BYTES - 1));
  assign body_dec   = (body_r != '0) ? body_r - BW'(1) : body_r;
  assign str_dec    = (str_r != '0) ? str_r - BW'(1) : str_r;

  always_comb begin
    phase_nxt  = phase_r;
    closed_nxt = closed_r;
    err_nxt    = err_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    body_nxt   = body_r;
    args_nxt   = args_r;
    cur_nxt    = cur_r;
    str_nxt    = str_r;
    item_end   = 1'b0;
    args_after = args_r;
    fail       = 1'b0;
    fail_code  = lpd_pkg::ERR_NONE;

    res.byte_out     = data_byte;
    res.byte_role    = lpd_pkg::ROLE_DISCARD;
    res.arg_index    = '0;
    res.string_last  = 1'b0;
    res.message_done = 1'b0;
    res.error_code   = lpd_pkg::ERR_NONE;

    if (closed_r) begin
      res.error_code = err_r;
    end else begin
      // Field accumulation shared by the three length/count fields.
      if (phase_r != PH_STR_BYTES) begin
        if (field_done) begin
          cnt_nxt   = '0;
          shift_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          case (cnt_r)
            2'd0:    shift_nxt[7:0]   = data_byte;
            2'd1:    shift_nxt[15:8]  = data_byte;
            default: shift_nxt[23:16] = data_byte;
          endcase
        end
      end
      if (phase_r != PH_BODY_LEN) begin
        body_nxt = body_dec;
      end

      case (phase_r)
        PH_BODY_LEN: begin
          res.byte_role = lpd_pkg::ROLE_BODY_LEN;
          if (field_done) begin
            if (field_full > 32'(cfg.max_body_bytes)) begin
              fail      = 1'b1;
              fail_code = lpd_pkg::ERR_BODY_BIG;
            end else if (field_full < 32'(lpd_pkg::LEN_FIELD_BYTES)) begin
              fail      = 1'b1;
              fail_code = lpd_pkg::ERR_PAST_END;
            end else begin
              body_nxt  = field_full[BW-1:0];
              phase_nxt = PH_ARG_COUNT;
            end
          end
        end
        PH_ARG_COUNT: begin
          res.byte_role = lpd_pkg::ROLE_ARG_COUNT;
          if (field_done) begin
            if (field_full > 32'(cfg.max_arg_count)) begin
              fail      = 1'b1;
              fail_code = lpd_pkg::ERR_MANY_ARGS;
            end else begin
              args_nxt   = field_full[AW-1:0];
              cur_nxt    = '0;
              item_end   = 1'b1;
              args_after = field_full[AW-1:0];
            end
          end
        end
        PH_STR_LEN: begin
          res.byte_role = lpd_pkg::ROLE_STR_LEN;
          res.arg_index = cur_r;
          if (field_done) begin
            if (field_full > 32'(body_dec)) begin
              fail      = 1'b1;
              fail_code = lpd_pkg::ERR_PAST_END;
            end else if (field_full == '0) begin
              // An empty string closes its argument right away.
              str_nxt    = '0;
              args_nxt   = args_r - AW'(1);
              cur_nxt    = cur_r + AW'(1);
              item_end   = 1'b1;
              args_after = args_r - AW'(1);
            end else begin
              str_nxt   = field_full[BW-1:0];
              phase_nxt = PH_STR_BYTES;
            end
          end
        end
        default: begin
          res.byte_role = lpd_pkg::ROLE_STR_BYTE;
          res.arg_index = cur_r;
          str_nxt       = str_dec;
          if (str_dec == '0) begin
            res.string_last = 1'b1;
            args_nxt        = args_r - AW'(1);
            cur_nxt         = cur_r + AW'(1);
            item_end        = 1'b1;
            args_after      = args_r - AW'(1);
          end
        end
      endcase

      // After an argument count or a whole string: finish the message, start
      // the next string length, or flag a malformed body.
      if (item_end) begin
        if (args_after == '0) begin
          if (body_dec == '0) begin
            res.message_done = 1'b1;
            phase_nxt        = PH_BODY_LEN;
          end else begin
            fail      = 1'b1;
            fail_code = lpd_pkg::ERR_TRAILING;
          end
        end else if (body_dec < BW'(lpd_pkg::LEN_FIELD_BYTES)) begin
          fail      = 1'b1;
          fail_code = lpd_pkg::ERR_PAST_END;
        end else begin
          phase_nxt = PH_STR_LEN;
        end
      end

      if (fail) begin
        closed_nxt     = 1'b1;
        err_nxt        = fail_code;
        res.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BODY_LEN;
      closed_r <= 1'b0;
      err_r    <= lpd_pkg::ERR_NONE;
      cnt_r    <= '0;
      shift_r  <= '0;
      body_r   <= '0;
      args_r   <= '0;
      cur_r    <= '0;
      str_r    <= '0;
    end else if (beat_fire) begin
      phase_r  <= phase_nxt;
      closed_r <= closed_nxt;
      err_r    <= err_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
      body_r   <= body_nxt;
      args_r   <= args_nxt;
      cur_r    <= cur_nxt;
      str_r    <= str_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lpd_out_buf.sv]
`default_nettype none
module lpd_out_buf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire lpd_pkg::lpd_result_t  up_data,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output lpd_pkg::lpd_result_t       dn_data
);

  logic                 main_valid_r;
  logic                 skid_valid_r;
  lpd_pkg::lpd_result_t main_r;
  lpd_pkg::lpd_result_t skid_r;
  logic                 up_fire;
  logic                 main_free;

  assign up_ready  = ~skid_valid_r;
  assign up_fire   = up_valid & up_ready;
  assign main_free = ~main_valid_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= up_fire;
      end
    end else if (up_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : up_data;
    end
    if (!main_free && up_fire) begin
      skid_r <= up_data;
    end
  end

  assign dn_valid = main_valid_r;
  assign dn_data  = main_r;

endmodule
`default_nettype wire

[hw/rtl/length_prefixed_request_deframer.sv]
`default_nettype none
// Each result beat is registered in the output buffer when its input beat is taken.
// One byte per cycle while in_tready is high; parser state updates on the accepting edge.
// A two-entry output buffer keeps the input open for one more beat while a result waits.
// Reset (rst_n, synchronous, active low) clears the parser to expect a body length,
// clears the sticky error and empties the output buffer; limits return to 4096 and 200000.
module length_prefixed_request_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Request byte stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte

  // Tagged byte stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] byte_out, [27:8] arg_index,
                                       // [28] string_last, [31:29] error_code
  output logic [2:0]       out_tuser,  // [2:0] byte_role
  output logic             out_tlast,  // message_done

  // Configuration registers: 0x0 max_body_bytes, 0x4 max_arg_count.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  lpd_pkg::lpd_cfg_t    cfg;
  lpd_pkg::lpd_result_t parse_res;
  lpd_pkg::lpd_result_t out_res;
  logic                 in_fire;

  // The register block holds the two limits that the parser checks against.
  lpd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_fire = in_tvalid & in_tready;

  // The parser tags each accepted byte combinationally from its current state and
  // advances that state on the same edge that accepts the beat.
  lpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (in_fire),
    .data_byte (in_tdata),
    .cfg       (cfg),
    .res       (parse_res)
  );

  // The output buffer registers each tagged beat and absorbs one extra beat when
  // the downstream side stalls, so in_tready comes from a register and not from
  // out_tready; a longer stall holds the input once both entries are full.
  lpd_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (parse_res),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_res)
  );

  assign out_tdata = {out_res.error_code, out_res.string_last,
                      out_res.arg_index, out_res.byte_out};
  assign out_tuser = out_res.byte_role;
  assign out_tlast = out_res.message_done;

endmodule
`default_nettype wire
